// ===== design/nlrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlrp_pkg: shared types for the node liveness round-robin picker
// request codes, result codes, result layout and controller/datapath links
// ----------------------------------------------------------------------------
package nlrp_pkg;

  localparam int NODE_SLOTS_DEF = 32;
  localparam int PICK_LIMIT_DEF = 3;
  localparam int MAX_RESULTS    = 32;
  localparam int KW             = $clog2(MAX_RESULTS + 1);
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;

  typedef enum logic [1:0] {
    ACT_HEARTBEAT,
    ACT_SELECT,
    ACT_SWEEP,
    ACT_COUNT
  } action_t;

  typedef enum logic [3:0] {
    ST_UPDATED,
    ST_INSERTED,
    ST_FULL,
    ST_PICKED,
    ST_NONE_LIVE,
    ST_DIED_PAIR,
    ST_DIED_NO_PAIR,
    ST_NONE_DIED,
    ST_COUNT
  } status_t;

  // first member lands in the top bits, so status sits lowest
  typedef struct packed {
    logic [5:0]  node_total;
    logic [4:0]  target_slot;
    logic [4:0]  source_slot;
    logic [15:0] out_port;
    logic [31:0] out_addr;
    logic [4:0]  slot;
    status_t     status;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HB_RD,
    S_HB_EV,
    S_HB_INS,
    S_SEL_RD,
    S_SEL_EV,
    S_SW_RD,
    S_SW_EV,
    S_PR_RD,
    S_PR_EV,
    S_SW_EMIT,
    S_SW_NEXT,
    S_CN_RD,
    S_CN_EV,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic    cap;
    logic    idx_clr;
    logic    idx_start;
    logic    idx_step;
    logic    rd_idx;
    logic    rd_outer;
    logic    outer_clr;
    logic    outer_step;
    logic    wr_touch;
    logic    wr_insert;
    logic    wr_kill;
    logic    pair_clr;
    logic    pair_take;
    logic    push;
    status_t push_code;
    logic    flush;
    status_t flush_code;
    logic    rot_adv;
    logic    tot_inc;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic full;
    logic hit;
    logic live;
    logic stale;
    logic not_dead;
    logic scan_end;
    logic idx_is_outer;
    logic outer_end;
    logic k_max;
    logic pick_last;
    logic pair_last;
    logic have_pair;
    logic push_ok;
    logic out_free;
  } stat_t;

endpackage

// ===== design/nlrp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlrp_dpath: node table datapath
// node memory, scan counters, result staging and output register
// ----------------------------------------------------------------------------
module nlrp_dpath #(
  parameter int NODE_SLOTS = nlrp_pkg::NODE_SLOTS_DEF,
  parameter int PICK_LIMIT = nlrp_pkg::PICK_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic [79:0]     in_data,
  input  nlrp_pkg::cmd_t  cmd,
  output nlrp_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [79:0]     out_data,
  output logic            out_last
);
  import nlrp_pkg::*;

  localparam int IW = $clog2(NODE_SLOTS);
  localparam int CW = $clog2(NODE_SLOTS + 1);

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] seen;
    logic        dead;
  } entry_t;

  entry_t mem [NODE_SLOTS];
  entry_t rdata;

  logic [15:0]   timeout;
  logic [31:0]   req_addr;
  logic [15:0]   req_port;
  logic [31:0]   req_now;
  logic [CW-1:0] count;
  logic [IW-1:0] rotate;
  logic [IW-1:0] idx;
  logic [IW-1:0] cnt;
  logic [IW-1:0] outer;
  logic [IW-1:0] src;
  logic [IW-1:0] dst;
  logic [1:0]    found;
  logic [KW-1:0] k;
  logic [CW-1:0] total;
  res_t          pend;
  logic          pend_valid;
  res_t          out_res;

  logic [IW-1:0] last_idx;
  logic [31:0]   age;
  logic          young;
  logic          out_free;
  res_t          new_res;
  res_t          fb_res;
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;

  assign last_idx = IW'(count - CW'(1));
  assign age      = req_now - rdata.seen;
  assign young    = age <= {16'd0, timeout};
  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat.n_zero       = count == '0;
    stat.full         = count == CW'(NODE_SLOTS);
    stat.hit          = rdata.addr == req_addr && rdata.port == req_port;
    stat.live         = !rdata.dead && young;
    stat.stale        = !rdata.dead && !young;
    stat.not_dead     = !rdata.dead;
    stat.scan_end     = cnt == last_idx;
    stat.idx_is_outer = idx == outer;
    stat.outer_end    = outer == last_idx;
    stat.k_max        = k == KW'(MAX_RESULTS);
    stat.pick_last    = k == KW'(PICK_LIMIT - 1);
    stat.pair_last    = found == 2'd1;
    stat.have_pair    = found == 2'd2;
    stat.push_ok      = !pend_valid || out_free;
    stat.out_free     = out_free;
  end

  // memory write selection
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rdata;
    if (cmd.wr_touch) begin
      we    = 1'b1;
      waddr = idx;
      wdata = '{addr: rdata.addr, port: rdata.port, seen: req_now, dead: 1'b0};
    end else if (cmd.wr_insert) begin
      we    = 1'b1;
      waddr = IW'(count);
      wdata = '{addr: req_addr, port: req_port, seen: req_now, dead: 1'b0};
    end else if (cmd.wr_kill) begin
      we         = 1'b1;
      waddr      = outer;
      wdata      = rdata;
      wdata.dead = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_idx) begin
      rdata <= mem[idx];
    end else if (cmd.rd_outer) begin
      rdata <= mem[outer];
    end
  end

  always_comb begin
    new_res        = '0;
    new_res.status = cmd.push_code;
    case (cmd.push_code)
      ST_UPDATED: new_res.slot = 5'(idx);
      ST_INSERTED: new_res.slot = 5'(count);
      ST_PICKED: begin
        new_res.slot     = 5'(idx);
        new_res.out_addr = rdata.addr;
        new_res.out_port = rdata.port;
      end
      ST_DIED_PAIR: begin
        new_res.slot        = 5'(outer);
        new_res.source_slot = 5'(src);
        new_res.target_slot = 5'(dst);
      end
      ST_DIED_NO_PAIR: new_res.slot = 5'(outer);
      default: new_res.slot = '0;
    endcase
  end

  always_comb begin
    fb_res            = '0;
    fb_res.status     = cmd.flush_code;
    fb_res.node_total = (cmd.flush_code == ST_COUNT) ? 6'(total) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_addr <= in_data[31:0];
      req_port <= in_data[47:32];
      req_now  <= in_data[79:48];
    end
    if (cmd.idx_clr) begin
      idx <= '0;
      cnt <= '0;
    end else if (cmd.idx_start) begin
      idx <= rotate;
      cnt <= '0;
    end else if (cmd.idx_step) begin
      idx <= (idx == last_idx) ? '0 : idx + IW'(1);
      cnt <= cnt + IW'(1);
    end
    if (cmd.outer_clr) begin
      outer <= '0;
    end else if (cmd.outer_step) begin
      outer <= outer + IW'(1);
    end
    if (cmd.pair_take) begin
      if (found == 2'd0) begin
        src <= idx;
      end else begin
        dst <= idx;
      end
    end
    if (cmd.push) begin
      pend <= new_res;
    end
    if (cmd.flush) begin
      out_res  <= pend_valid ? pend : fb_res;
      out_last <= 1'b1;
    end else if (cmd.push && pend_valid) begin
      out_res  <= pend;
      out_last <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout    <= TIMEOUT_RESET;
      count      <= '0;
      rotate     <= '0;
      found      <= '0;
      k          <= '0;
      total      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (cmd.wr_insert) begin
        count <= count + CW'(1);
      end
      if (cmd.rot_adv) begin
        rotate <= (rotate == last_idx) ? '0 : rotate + IW'(1);
      end
      if (cmd.pair_clr) begin
        found <= '0;
      end else if (cmd.pair_take) begin
        found <= found + 2'd1;
      end
      if (cmd.cap) begin
        k     <= '0;
        total <= '0;
      end else begin
        if (cmd.push) begin
          k <= k + KW'(1);
        end
        if (cmd.tot_inc) begin
          total <= total + CW'(1);
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end else if (cmd.push) begin
        pend_valid <= 1'b1;
      end
      if (cmd.flush || (cmd.push && pend_valid)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_data = {7'd0, out_res};

endmodule

// ===== design/nlrp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlrp_ctrl: request sequencer
// walks the node table for each request and issues datapath commands
// ----------------------------------------------------------------------------
module nlrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  nlrp_pkg::action_t in_action,
  input  nlrp_pkg::stat_t   stat,
  output nlrp_pkg::cmd_t    cmd
);
  import nlrp_pkg::*;

  state_t  state;
  state_t  state_next;
  action_t act;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= ACT_HEARTBEAT;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) begin
        act <= in_action;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_HEARTBEAT: state_next = stat.n_zero ? S_HB_INS : S_HB_RD;
            ACT_SELECT:    state_next = stat.n_zero ? S_FLUSH : S_SEL_RD;
            ACT_SWEEP:     state_next = stat.n_zero ? S_FLUSH : S_SW_RD;
            default:       state_next = stat.n_zero ? S_FLUSH : S_CN_RD;
          endcase
        end
      end
      S_HB_RD: state_next = S_HB_EV;
      S_HB_EV: begin
        if (stat.hit) begin
          state_next = S_FLUSH;
        end else if (stat.scan_end) begin
          state_next = S_HB_INS;
        end else begin
          state_next = S_HB_RD;
        end
      end
      S_HB_INS: state_next = S_FLUSH;
      S_SEL_RD: state_next = S_SEL_EV;
      S_SEL_EV: begin
        if (stat.live && !stat.push_ok) begin
          state_next = S_SEL_EV;
        end else if (stat.scan_end || (stat.live && stat.pick_last)) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_SEL_RD;
        end
      end
      S_SW_RD: state_next = S_SW_EV;
      S_SW_EV: state_next = stat.stale ? S_PR_RD : S_SW_NEXT;
      S_PR_RD: state_next = S_PR_EV;
      S_PR_EV: begin
        if (stat.scan_end ||
            (stat.live && !stat.idx_is_outer && stat.pair_last)) begin
          state_next = S_SW_EMIT;
        end else begin
          state_next = S_PR_RD;
        end
      end
      S_SW_EMIT: state_next = stat.push_ok ? S_SW_NEXT : S_SW_EMIT;
      S_SW_NEXT: state_next = (stat.outer_end || stat.k_max) ? S_FLUSH : S_SW_RD;
      S_CN_RD: state_next = S_CN_EV;
      S_CN_EV: state_next = stat.scan_end ? S_FLUSH : S_CN_RD;
      S_FLUSH: state_next = stat.out_free ? S_IDLE : S_FLUSH;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.push_code = ST_UPDATED;
    case (act)
      ACT_HEARTBEAT: cmd.flush_code = ST_FULL;
      ACT_SELECT:    cmd.flush_code = ST_NONE_LIVE;
      ACT_SWEEP:     cmd.flush_code = ST_NONE_DIED;
      default:       cmd.flush_code = ST_COUNT;
    endcase
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          case (in_action)
            ACT_SELECT: cmd.idx_start = 1'b1;
            ACT_SWEEP:  cmd.outer_clr = 1'b1;
            default:    cmd.idx_clr   = 1'b1;
          endcase
        end
      end
      S_HB_RD, S_SEL_RD, S_PR_RD, S_CN_RD: cmd.rd_idx = 1'b1;
      S_SW_RD: cmd.rd_outer = 1'b1;
      S_HB_EV: begin
        if (stat.hit) begin
          cmd.wr_touch  = 1'b1;
          cmd.push      = 1'b1;
          cmd.push_code = ST_UPDATED;
        end else if (!stat.scan_end) begin
          cmd.idx_step = 1'b1;
        end
      end
      S_HB_INS: begin
        if (!stat.full) begin
          cmd.wr_insert = 1'b1;
          cmd.push      = 1'b1;
          cmd.push_code = ST_INSERTED;
        end
      end
      S_SEL_EV: begin
        cmd.push_code = ST_PICKED;
        if (!(stat.live && !stat.push_ok)) begin
          cmd.push = stat.live;
          if (stat.scan_end || (stat.live && stat.pick_last)) begin
            cmd.rot_adv = 1'b1;
          end else begin
            cmd.idx_step = 1'b1;
          end
        end
      end
      S_SW_EV: begin
        if (stat.stale) begin
          cmd.wr_kill  = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.pair_clr = 1'b1;
        end
      end
      S_PR_EV: begin
        cmd.pair_take = stat.live && !stat.idx_is_outer;
        if (!(stat.scan_end ||
              (stat.live && !stat.idx_is_outer && stat.pair_last))) begin
          cmd.idx_step = 1'b1;
        end
      end
      S_SW_EMIT: begin
        cmd.push_code = stat.have_pair ? ST_DIED_PAIR : ST_DIED_NO_PAIR;
        cmd.push      = stat.push_ok;
      end
      S_SW_NEXT: begin
        if (!(stat.outer_end || stat.k_max)) begin
          cmd.outer_step = 1'b1;
        end
      end
      S_CN_EV: begin
        cmd.tot_inc  = stat.not_dead;
        cmd.idx_step = !stat.scan_end;
      end
      S_FLUSH: cmd.flush = stat.out_free;
      default: cmd.flush = 1'b0;
    endcase
  end

endmodule

// ===== design/node_liveness_round_robin_picker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_liveness_round_robin_picker_core: storage node liveness table
// heartbeat, round-robin select, liveness sweep and node count requests
// ----------------------------------------------------------------------------
// one request at a time; each entry visited takes an address state and then a
// registered read data state; each request adds an accept state and a flush state
// sweep: an inner pair scan follows each newly dead node
// results leave through one output register; result stalls add cycles
// reset (sync, active high) empties the table, clears the offset, timeout 15 s
module node_liveness_round_robin_picker_core #(
  parameter int NODE_SLOTS = nlrp_pkg::NODE_SLOTS_DEF,
  parameter int PICK_LIMIT = nlrp_pkg::PICK_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // timeout_seconds register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // node_addr[31:0], node_port[47:32], now_seconds[79:48]
  input  logic [1:0]  s_tuser,   // action[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // status[3:0], slot[8:4], out_addr[40:9], out_port[56:41],
                                 // source_slot[61:57], target_slot[66:62],
                                 // node_total[72:67], zero fill
  output logic        m_tlast    // last result of the request
);
  import nlrp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one state per table walk phase
  nlrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (action_t'(s_tuser)),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table memory, counters and result path
  nlrp_dpath #(
    .NODE_SLOTS (NODE_SLOTS),
    .PICK_LIMIT (PICK_LIMIT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
